// File: rtl/cia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_pkg
// Operation and fault codes used by the checked integer ALU and its bench.
// ----------------------------------------------------------------------------
package cia_pkg;

    typedef enum logic [4:0] {
        OP_ADD = 5'd0,
        OP_SUB = 5'd1,
        OP_MUL = 5'd2,
        OP_DIV = 5'd3,
        OP_MOD = 5'd4,
        OP_AND = 5'd5,
        OP_OR  = 5'd6,
        OP_XOR = 5'd7,
        OP_NOT = 5'd8,
        OP_SHL = 5'd9,
        OP_SHR = 5'd10,
        OP_NEG = 5'd11,
        OP_INC = 5'd12,
        OP_DEC = 5'd13,
        OP_EQ  = 5'd14,
        OP_NE  = 5'd15,
        OP_LT  = 5'd16,
        OP_GT  = 5'd17,
        OP_LE  = 5'd18,
        OP_GE  = 5'd19
    } op_t;

    localparam logic [2:0] FAULT_NONE    = 3'd0;
    localparam logic [2:0] FAULT_OVF     = 3'd1;
    localparam logic [2:0] FAULT_DIV0    = 3'd2;
    localparam logic [2:0] FAULT_SHIFT   = 3'd3;
    localparam logic [2:0] FAULT_ILLEGAL = 3'd4;

endpackage
`default_nettype wire

// File: rtl/cia_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_req_if
// Request channel of the ALU: operation, operands and signedness.
// ----------------------------------------------------------------------------
interface cia_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  op;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic        is_signed;

    modport source (output valid, op, operand_a, operand_b, is_signed, input ready);
    modport sink   (input valid, op, operand_a, operand_b, is_signed, output ready);
endinterface
`default_nettype wire

// File: rtl/cia_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_rsp_if
// Response channel of the ALU: wrapped result and fault code.
// ----------------------------------------------------------------------------
interface cia_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;
    logic [2:0]  fault;

    modport source (output valid, result, fault, input ready);
    modport sink   (input valid, result, fault, output ready);
endinterface
`default_nettype wire

// File: rtl/checked_integer_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checked_integer_alu
// Pipelined integer ALU that returns a wrapped result and a fault code.
// ----------------------------------------------------------------------------
// Requests arrive on req (op, operand_a, operand_b, is_signed) and each one
// produces exactly one response on rsp (result, fault), in request order.
// Throughput is one request per cycle while the response is not stalled. The
// pipeline holds one input register, one stage that forms the simple results
// and the product, MW restoring divider stages that each settle one quotient
// bit, and the output register, where MW is the smaller of WIDTH and 32. Every
// operation takes the same path, so the divider length sets the latency.
// The whole pipeline advances together: when the response is held by a
// stalled receiver, all stages hold and req.ready drops; no request is lost
// or repeated. Reset clears all valid bits; the pipeline is empty afterward.
// Operands are read from the low WIDTH bits of the 32-bit fields, and the
// result keeps the low 32 bits of the WIDTH-bit value.
// ----------------------------------------------------------------------------
module checked_integer_alu #(
    parameter int WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cia_req_if.sink   req,
    cia_rsp_if.source rsp
);

    localparam int MW = (WIDTH < 32) ? WIDTH : 32;
    localparam int SW = $clog2(WIDTH);
    localparam logic [WIDTH:0] WLIM = (WIDTH + 1)'(WIDTH);
    localparam logic [WIDTH-1:0] WSIGN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] WMASK = {WIDTH{1'b1}};
    localparam logic [WIDTH-1:0] SMAX = {1'b0, {(WIDTH-1){1'b1}}};

    typedef struct packed {
        logic [4:0]      op;
        logic            sgn;
        logic            an;
        logic            bn;
        logic            use_div;
        logic [WIDTH-1:0] r;
        logic [2:0]      f;
        logic [2*MW-1:0] prod;
        logic [MW-1:0]   mb;
        logic [MW:0]     rem;
        logic [MW-1:0]   qd;
    } rec_t;

    logic advance;
    assign advance   = !rsp.valid || rsp.ready;
    assign req.ready = advance;

    // Input register
    logic [63:0]      a64;
    logic [63:0]      b64;
    logic [WIDTH-1:0] a_in;
    logic [WIDTH-1:0] b_in;
    logic [MW-1:0]    ma_in;
    logic [MW-1:0]    mb_in;

    assign a64  = {32'd0, req.operand_a};
    assign b64  = {32'd0, req.operand_b};
    assign a_in = a64[WIDTH-1:0];
    assign b_in = b64[WIDTH-1:0];
    assign ma_in = (req.is_signed && a_in[WIDTH-1]) ? (MW)'(-a_in[MW-1:0]) : a_in[MW-1:0];
    assign mb_in = (req.is_signed && b_in[WIDTH-1]) ? (MW)'(-b_in[MW-1:0]) : b_in[MW-1:0];

    logic             s1_valid_reg;
    logic [4:0]       s1_op_reg;
    logic             s1_sgn_reg;
    logic [WIDTH-1:0] s1_a_reg;
    logic [WIDTH-1:0] s1_b_reg;
    logic [MW-1:0]    s1_ma_reg;
    logic [MW-1:0]    s1_mb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg  <= req.op;
            s1_sgn_reg <= req.is_signed;
            s1_a_reg   <= a_in;
            s1_b_reg   <= b_in;
            s1_ma_reg  <= ma_in;
            s1_mb_reg  <= mb_in;
        end
    end

    // Simple operations and the product
    rec_t s2_next;
    logic an;
    logic bn;
    logic a_lt_b;
    logic b_lt_a;
    logic [WIDTH-1:0] sum;
    logic [WIDTH-1:0] diff;
    logic [WIDTH-1:0] one_w;

    assign an     = s1_a_reg[WIDTH-1];
    assign bn     = s1_b_reg[WIDTH-1];
    assign one_w  = {{(WIDTH-1){1'b0}}, 1'b1};
    assign sum    = s1_a_reg + s1_b_reg;
    assign diff   = s1_a_reg - s1_b_reg;
    assign a_lt_b = s1_sgn_reg ? ((s1_a_reg ^ WSIGN) < (s1_b_reg ^ WSIGN))
                               : (s1_a_reg < s1_b_reg);
    assign b_lt_a = s1_sgn_reg ? ((s1_b_reg ^ WSIGN) < (s1_a_reg ^ WSIGN))
                               : (s1_b_reg < s1_a_reg);

    always_comb
    begin
        s2_next         = '0;
        s2_next.op      = s1_op_reg;
        s2_next.sgn     = s1_sgn_reg;
        s2_next.an      = an;
        s2_next.bn      = bn;
        s2_next.prod    = s1_ma_reg * s1_mb_reg;
        s2_next.mb      = s1_mb_reg;
        s2_next.qd      = s1_ma_reg;
        s2_next.r       = '0;
        s2_next.f       = cia_pkg::FAULT_NONE;
        case (s1_op_reg)
            cia_pkg::OP_ADD:
            begin
                s2_next.r = sum;
                if (s1_sgn_reg ? ((an ^ sum[WIDTH-1]) & (bn ^ sum[WIDTH-1]))
                               : (sum < s1_a_reg))
                    s2_next.f = cia_pkg::FAULT_OVF;
            end
            cia_pkg::OP_SUB:
            begin
                s2_next.r = diff;
                if (s1_sgn_reg ? ((an ^ bn) & (an ^ diff[WIDTH-1]))
                               : (s1_b_reg > s1_a_reg))
                    s2_next.f = cia_pkg::FAULT_OVF;
            end
            cia_pkg::OP_MUL:
            begin
                // Result and overflow are formed at the end from the product.
                s2_next.r = '0;
            end
            cia_pkg::OP_DIV, cia_pkg::OP_MOD:
            begin
                if (s1_b_reg == '0)
                    s2_next.f = cia_pkg::FAULT_DIV0;
                else if (s1_sgn_reg && s1_a_reg == WSIGN && s1_b_reg == WMASK)
                begin
                    s2_next.f = cia_pkg::FAULT_OVF;
                    s2_next.r = (s1_op_reg == cia_pkg::OP_DIV) ? WSIGN : '0;
                end
                else
                    s2_next.use_div = 1'b1;
            end
            cia_pkg::OP_AND, cia_pkg::OP_OR, cia_pkg::OP_XOR,
            cia_pkg::OP_NOT, cia_pkg::OP_SHL, cia_pkg::OP_SHR:
            begin
                if (s1_sgn_reg)
                    s2_next.f = cia_pkg::FAULT_ILLEGAL;
                else if (s1_op_reg == cia_pkg::OP_AND)
                    s2_next.r = s1_a_reg & s1_b_reg;
                else if (s1_op_reg == cia_pkg::OP_OR)
                    s2_next.r = s1_a_reg | s1_b_reg;
                else if (s1_op_reg == cia_pkg::OP_XOR)
                    s2_next.r = s1_a_reg ^ s1_b_reg;
                else if (s1_op_reg == cia_pkg::OP_NOT)
                    s2_next.r = ~s1_a_reg;
                else if ({1'b0, s1_b_reg} >= WLIM)
                    s2_next.f = cia_pkg::FAULT_SHIFT;
                else if (s1_op_reg == cia_pkg::OP_SHL)
                    s2_next.r = s1_a_reg << s1_b_reg[SW-1:0];
                else
                    s2_next.r = s1_a_reg >> s1_b_reg[SW-1:0];
            end
            cia_pkg::OP_NEG:
            begin
                if (!s1_sgn_reg)
                    s2_next.f = cia_pkg::FAULT_ILLEGAL;
                else
                begin
                    s2_next.r = -s1_a_reg;
                    if (s1_a_reg == WSIGN)
                        s2_next.f = cia_pkg::FAULT_OVF;
                end
            end
            cia_pkg::OP_INC:
            begin
                s2_next.r = s1_a_reg + one_w;
                if (s1_a_reg == (s1_sgn_reg ? SMAX : WMASK))
                    s2_next.f = cia_pkg::FAULT_OVF;
            end
            cia_pkg::OP_DEC:
            begin
                s2_next.r = s1_a_reg - one_w;
                if (s1_a_reg == (s1_sgn_reg ? WSIGN : '0))
                    s2_next.f = cia_pkg::FAULT_OVF;
            end
            cia_pkg::OP_EQ: s2_next.r = {{(WIDTH-1){1'b0}}, s1_a_reg == s1_b_reg};
            cia_pkg::OP_NE: s2_next.r = {{(WIDTH-1){1'b0}}, s1_a_reg != s1_b_reg};
            cia_pkg::OP_LT: s2_next.r = {{(WIDTH-1){1'b0}}, a_lt_b};
            cia_pkg::OP_GT: s2_next.r = {{(WIDTH-1){1'b0}}, b_lt_a};
            cia_pkg::OP_LE: s2_next.r = {{(WIDTH-1){1'b0}}, !b_lt_a};
            cia_pkg::OP_GE: s2_next.r = {{(WIDTH-1){1'b0}}, !a_lt_b};
            default:        s2_next.f = cia_pkg::FAULT_ILLEGAL;
        endcase
    end

    // Stage 0 of this array is the record after the product stage; each
    // later stage settles one quotient bit, most significant first.
    rec_t dv_reg [0:MW];
    logic dv_valid_reg [0:MW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            dv_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dv_reg[0] <= s2_next;
        end
    end

    for (genvar k = 0; k < MW; k++)
    begin : g_div
        rec_t        st_next;
        logic [MW:0] trial;

        assign trial = {dv_reg[k].rem[MW-1:0], dv_reg[k].qd[MW-1]};

        always_comb
        begin
            st_next = dv_reg[k];
            if (trial >= {1'b0, dv_reg[k].mb})
            begin
                st_next.rem = trial - {1'b0, dv_reg[k].mb};
                st_next.qd  = {dv_reg[k].qd[MW-2:0], 1'b1};
            end
            else
            begin
                st_next.rem = trial;
                st_next.qd  = {dv_reg[k].qd[MW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dv_reg[k+1] <= st_next;
            end
        end
    end

    // Final result
    rec_t             fin;
    logic [2*MW-1:0]  prod_sel;
    logic [127:0]     prod_ext;
    logic [127:0]     lim_ext;
    logic [WIDTH-1:0] mul_lim;
    logic [MW-1:0]    div_val;
    logic [MW-1:0]    div_sel;
    logic             div_neg;
    logic [63:0]      div_ext;
    logic [WIDTH-1:0] r_fin;
    logic [2:0]       f_fin;
    logic [63:0]      r_ext;

    assign fin      = dv_reg[MW];
    assign prod_sel = (fin.sgn && (fin.an ^ fin.bn)) ? (2*MW)'(-fin.prod) : fin.prod;
    assign prod_ext = {{(128-2*MW){1'b0}}, fin.prod};
    assign mul_lim  = fin.sgn ? ((fin.an ^ fin.bn) ? WSIGN : SMAX) : WMASK;
    assign lim_ext  = {{(128-WIDTH){1'b0}}, mul_lim};
    assign div_val  = (fin.op == cia_pkg::OP_DIV) ? fin.qd : fin.rem[MW-1:0];
    assign div_neg  = fin.sgn && ((fin.op == cia_pkg::OP_DIV) ? (fin.an ^ fin.bn) : fin.an);
    assign div_sel  = div_neg ? (MW)'(-div_val) : div_val;
    assign div_ext  = {{(64-MW){1'b0}}, div_sel};

    logic [127:0] prod_sel_ext;
    assign prod_sel_ext = {{(128-2*MW){1'b0}}, prod_sel};

    always_comb
    begin
        r_fin = fin.r;
        f_fin = fin.f;
        if (fin.op == cia_pkg::OP_MUL)
        begin
            r_fin = prod_sel_ext[WIDTH-1:0];
            f_fin = (prod_ext > lim_ext) ? cia_pkg::FAULT_OVF : cia_pkg::FAULT_NONE;
        end
        else if (fin.use_div)
        begin
            r_fin = div_ext[WIDTH-1:0];
        end
    end

    always_comb
    begin
        r_ext = '0;
        r_ext[WIDTH-1:0] = r_fin;
    end

    logic        out_valid_reg;
    logic [31:0] out_result_reg;
    logic [2:0]  out_fault_reg;
    logic [4:0]  out_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dv_valid_reg[MW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= r_ext[31:0];
            out_fault_reg  <= f_fin;
            out_op_reg     <= fin.op;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.result = out_result_reg;
    assign rsp.fault  = out_fault_reg;

    // Checks
    a_cmp_is_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fault_reg == cia_pkg::FAULT_NONE
         && (out_op_reg == cia_pkg::OP_EQ || out_op_reg == cia_pkg::OP_NE
             || out_op_reg == cia_pkg::OP_LT || out_op_reg == cia_pkg::OP_GT
             || out_op_reg == cia_pkg::OP_LE || out_op_reg == cia_pkg::OP_GE))
        |-> (out_result_reg[31:1] == '0))
        else $error("comparison result is not a single bit");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_fault_reg == cia_pkg::FAULT_DIV0
         || out_fault_reg == cia_pkg::FAULT_SHIFT
         || out_fault_reg == cia_pkg::FAULT_ILLEGAL))
        |-> (out_result_reg == '0))
        else $error("faulted request returned a nonzero result");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[MW] && fin.use_div) |-> (fin.rem < {1'b0, fin.mb}))
        else $error("divider remainder not below divisor");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_fault_reg <= cia_pkg::FAULT_ILLEGAL))
        else $error("fault code out of range");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the checked integer ALU.
// A directed table of requests runs first, then random requests biased toward
// operand corner values. Each response is compared with its table value, or with a local model where none is given.
// ----------------------------------------------------------------------------
module tb;

    localparam int W = 32;
    localparam int N_RANDOM = 1680;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [31:0] SMIN = 32'h8000_0000;
    localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] result;
        logic [2:0]  fault;
    } alu_out_t;

    typedef struct {
        logic [4:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic        sgn;
        logic        known;
        alu_out_t    want;
    } vec_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   idle_cycles = 0;

    cia_req_if req();
    cia_rsp_if rsp();

    checked_integer_alu #(.WIDTH(W)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    alu_out_t pending_results[$];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] mag(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic bit lt_cmp(logic [31:0] x, logic [31:0] y, logic sgn);
        return sgn ? ($signed(x) < $signed(y)) : (x < y);
    endfunction

    function automatic alu_out_t alu_predict(logic [4:0] op, logic [31:0] a,
                                             logic [31:0] b, logic sgn);
        alu_out_t o;
        logic [63:0] prod;
        logic [31:0] ma;
        logic [31:0] mb;
        o.result = '0;
        o.fault  = cia_pkg::FAULT_NONE;
        case (op)
            cia_pkg::OP_ADD:
            begin
                o.result = a + b;
                if (sgn ? ((a[31] == b[31]) && (o.result[31] != a[31])) : (o.result < a))
                    o.fault = cia_pkg::FAULT_OVF;
            end
            cia_pkg::OP_SUB:
            begin
                o.result = a - b;
                if (sgn ? ((a[31] != b[31]) && (o.result[31] != a[31])) : (b > a))
                    o.fault = cia_pkg::FAULT_OVF;
            end
            cia_pkg::OP_MUL:
            begin
                o.result = a * b;
                if (sgn)
                begin
                    prod = {32'd0, mag(a)} * {32'd0, mag(b)};
                    if (prod > ((a[31] != b[31]) ? {32'd0, SMIN} : {32'd0, SMAX}))
                        o.fault = cia_pkg::FAULT_OVF;
                end
                else
                begin
                    prod = {32'd0, a} * {32'd0, b};
                    if (prod[63:32] != 32'd0)
                        o.fault = cia_pkg::FAULT_OVF;
                end
            end
            cia_pkg::OP_DIV, cia_pkg::OP_MOD:
            begin
                if (b == 32'd0)
                    o.fault = cia_pkg::FAULT_DIV0;
                else if (!sgn)
                    o.result = (op == cia_pkg::OP_DIV) ? a / b : a % b;
                else if (a == SMIN && b == ALL1)
                begin
                    o.fault  = cia_pkg::FAULT_OVF;
                    o.result = (op == cia_pkg::OP_DIV) ? SMIN : 32'd0;
                end
                else
                begin
                    ma = mag(a);
                    mb = mag(b);
                    if (op == cia_pkg::OP_DIV)
                        o.result = (a[31] != b[31]) ? -(ma / mb) : ma / mb;
                    else
                        o.result = a[31] ? -(ma % mb) : ma % mb;
                end
            end
            cia_pkg::OP_AND, cia_pkg::OP_OR, cia_pkg::OP_XOR,
            cia_pkg::OP_NOT, cia_pkg::OP_SHL, cia_pkg::OP_SHR:
            begin
                if (sgn)
                    o.fault = cia_pkg::FAULT_ILLEGAL;
                else if (op == cia_pkg::OP_AND)
                    o.result = a & b;
                else if (op == cia_pkg::OP_OR)
                    o.result = a | b;
                else if (op == cia_pkg::OP_XOR)
                    o.result = a ^ b;
                else if (op == cia_pkg::OP_NOT)
                    o.result = ~a;
                else if (b >= 32'(W))
                    o.fault = cia_pkg::FAULT_SHIFT;
                else if (op == cia_pkg::OP_SHL)
                    o.result = a << b;
                else
                    o.result = a >> b;
            end
            cia_pkg::OP_NEG:
            begin
                if (!sgn)
                    o.fault = cia_pkg::FAULT_ILLEGAL;
                else
                begin
                    o.result = -a;
                    if (a == SMIN)
                        o.fault = cia_pkg::FAULT_OVF;
                end
            end
            cia_pkg::OP_INC:
            begin
                o.result = a + 32'd1;
                if (a == (sgn ? SMAX : ALL1))
                    o.fault = cia_pkg::FAULT_OVF;
            end
            cia_pkg::OP_DEC:
            begin
                o.result = a - 32'd1;
                if (a == (sgn ? SMIN : 32'd0))
                    o.fault = cia_pkg::FAULT_OVF;
            end
            cia_pkg::OP_EQ: o.result = {31'd0, a == b};
            cia_pkg::OP_NE: o.result = {31'd0, a != b};
            cia_pkg::OP_LT: o.result = {31'd0, lt_cmp(a, b, sgn)};
            cia_pkg::OP_GT: o.result = {31'd0, lt_cmp(b, a, sgn)};
            cia_pkg::OP_LE: o.result = {31'd0, !lt_cmp(b, a, sgn)};
            cia_pkg::OP_GE: o.result = {31'd0, !lt_cmp(a, b, sgn)};
            default: o.fault = cia_pkg::FAULT_ILLEGAL;
        endcase
        return o;
    endfunction

    function automatic vec_t mk(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                                logic sgn, logic known, logic [31:0] r, logic [2:0] f);
        vec_t v;
        v.op = op;
        v.a = a;
        v.b = b;
        v.sgn = sgn;
        v.known = known;
        v.want.result = r;
        v.want.fault = f;
        return v;
    endfunction

    function automatic logic [31:0] corner_operand();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return ALL1;
            3: return SMIN;
            4: return SMAX;
            5: return $urandom_range(0, 40);
            6: return 32'd1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Issue one request, then wait for it to be taken. The valid line is
    // dropped only for an idle gap before the request.
    task automatic send_request(vec_t v);
        alu_out_t model;
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.op        <= v.op;
        req.operand_a <= v.a;
        req.operand_b <= v.b;
        req.is_signed <= v.sgn;
        model = alu_predict(v.op, v.a, v.b, v.sgn);
        if (v.known && model != v.want)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("table row op=%0d a=%h b=%h: table %h/%0d model %h/%0d",
                         v.op, v.a, v.b, v.want.result, v.want.fault,
                         model.result, model.fault);
        end
        pending_results.push_back(v.known ? v.want : model);
        @(posedge clk);
        while (!req.ready) @(posedge clk);
    endtask

    // Response side: random back-pressure and comparison.
    initial
    begin
        alu_out_t want;
        int stall;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid) @(posedge clk);
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected response %h/%0d", rsp.result, rsp.fault);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.result !== want.result || rsp.fault !== want.fault)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %h/%0d, got %h/%0d",
                                 want.result, want.fault, rsp.result, rsp.fault);
                end
            end
        end
    end

    // Watchdog over cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        vec_t table_rows[$];
        vec_t v;
        int k;
        fail_count = 0;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.op <= '0;
        req.operand_a <= '0;
        req.operand_b <= '0;
        req.is_signed <= 1'b0;

        table_rows.push_back(mk(cia_pkg::OP_ADD, ALL1, 32'd1, 1'b0, 1'b1, 32'd0,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_ADD, SMAX, 32'd1, 1'b1, 1'b1, SMIN,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_SUB, 32'd0, 32'd1, 1'b0, 1'b1, ALL1,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_SUB, SMIN, 32'd1, 1'b1, 1'b1, SMAX,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_MUL, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b1,
                                32'd0, cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_MUL, SMIN, ALL1, 1'b1, 1'b0, 32'd0,
                                cia_pkg::FAULT_NONE));
        table_rows.push_back(mk(cia_pkg::OP_MUL, 32'h0001_0000, 32'hFFFF_8000, 1'b1, 1'b0,
                                32'd0, cia_pkg::FAULT_NONE));
        table_rows.push_back(mk(cia_pkg::OP_DIV, SMIN, ALL1, 1'b1, 1'b1, SMIN,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_MOD, SMIN, ALL1, 1'b1, 1'b1, 32'd0,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_DIV, 32'd5, 32'd0, 1'b0, 1'b1, 32'd0,
                                cia_pkg::FAULT_DIV0));
        table_rows.push_back(mk(cia_pkg::OP_MOD, 32'd5, 32'd0, 1'b1, 1'b1, 32'd0,
                                cia_pkg::FAULT_DIV0));
        table_rows.push_back(mk(cia_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd2, 1'b1, 1'b0, 32'd0,
                                cia_pkg::FAULT_NONE));
        table_rows.push_back(mk(cia_pkg::OP_MOD, 32'hFFFF_FFF9, 32'd2, 1'b1, 1'b0, 32'd0,
                                cia_pkg::FAULT_NONE));
        table_rows.push_back(mk(cia_pkg::OP_AND, ALL1, ALL1, 1'b1, 1'b1, 32'd0,
                                cia_pkg::FAULT_ILLEGAL));
        table_rows.push_back(mk(cia_pkg::OP_SHL, 32'd1, 32'd32, 1'b1, 1'b1, 32'd0,
                                cia_pkg::FAULT_ILLEGAL));
        table_rows.push_back(mk(cia_pkg::OP_SHR, ALL1, 32'd32, 1'b0, 1'b1, 32'd0,
                                cia_pkg::FAULT_SHIFT));
        table_rows.push_back(mk(cia_pkg::OP_SHL, ALL1, 32'd31, 1'b0, 1'b1, SMIN,
                                cia_pkg::FAULT_NONE));
        table_rows.push_back(mk(cia_pkg::OP_NOT, 32'd0, 32'd0, 1'b0, 1'b1, ALL1,
                                cia_pkg::FAULT_NONE));
        table_rows.push_back(mk(cia_pkg::OP_NEG, 32'd1, 32'd0, 1'b0, 1'b1, 32'd0,
                                cia_pkg::FAULT_ILLEGAL));
        table_rows.push_back(mk(cia_pkg::OP_NEG, SMIN, 32'd0, 1'b1, 1'b1, SMIN,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_INC, ALL1, 32'd0, 1'b0, 1'b1, 32'd0,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_DEC, SMIN, 32'd0, 1'b1, 1'b1, SMAX,
                                cia_pkg::FAULT_OVF));
        table_rows.push_back(mk(cia_pkg::OP_LT, SMIN, 32'd0, 1'b1, 1'b1, 32'd1,
                                cia_pkg::FAULT_NONE));
        table_rows.push_back(mk(cia_pkg::OP_GE, SMIN, 32'd0, 1'b0, 1'b1, 32'd1,
                                cia_pkg::FAULT_NONE));
        table_rows.push_back(mk(5'd31, ALL1, ALL1, 1'b1, 1'b1, 32'd0,
                                cia_pkg::FAULT_ILLEGAL));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_request(table_rows[i]);

        for (k = 0; k < N_RANDOM; k++)
        begin
            v.known = 1'b0;
            v.op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
                                                : 5'($urandom_range(0, 19));
            v.sgn = 1'($urandom_range(0, 1));
            v.a = corner_operand();
            v.b = corner_operand();
            if (v.op == cia_pkg::OP_SHL || v.op == cia_pkg::OP_SHR)
                v.b = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
            send_request(v);
        end
        req.valid <= 1'b0;

        k = 0;
        while (pending_results.size() != 0 && k < 5000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
